/* rtl/flux_limiter_unit_assert.svh */
// ----------------------------------------------------------------------------
// flux_limiter_unit_assert.svh - assertion macros
// Clocked on i_clk; all but the reset form are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLUX_LIMITER_UNIT_ASSERT_SVH
`define FLUX_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define FLU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define FLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define FLU_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/flu_pkg.sv */
// ----------------------------------------------------------------------------
// flu_pkg - flux limiter shared types and constants
// Limiter codes, stage control word and fixed widths.
// ----------------------------------------------------------------------------
package flu_pkg;

    localparam int FRAC_BITS_DEF = 16;   // Q16.16 in, Q.16 out
    localparam int RATIO_W       = 32;   // input word width
    localparam int DEN_W         = 32;   // 1.0 + r always fits
    localparam int DIV_STEP      = 2;    // quotient bits per divider stage
    localparam int CFG_W         = 2;

    typedef enum logic [CFG_W-1:0] {
        MODE_MC       = 2'd0,
        MODE_MINMOD   = 2'd1,
        MODE_SUPERBEE = 2'd2,
        MODE_VANLEER  = 2'd3
    } t_mode;

    // control travelling alongside each word
    typedef struct packed {
        logic  valid;
        logic  pos;      // ratio strictly positive
        t_mode mode;
    } t_ctl;

endpackage

/* rtl/flu_front.sv */
// ----------------------------------------------------------------------------
// flu_front - input capture and closed-form limiters
// Stage 1 registers the ratio and its clamp; stage 2 forms MC / minmod /
// superbee and seeds the divider with remainder and divisor.
// ----------------------------------------------------------------------------
module flu_front #(
    parameter int FRAC_BITS = flu_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [flu_pkg::RATIO_W-1:0]  i_ratio,
    input  flu_pkg::t_mode               i_mode,
    output flu_pkg::t_ctl                o_ctl,
    output logic [flu_pkg::DEN_W-1:0]    o_rem,
    output logic [flu_pkg::DEN_W-1:0]    o_den,
    output logic [FRAC_BITS+1:0]         o_aux
);

    localparam int PHI_W = FRAC_BITS + 2;
    localparam int CL_W  = FRAC_BITS + 3;   // holds 4.0
    localparam int WK_W  = FRAC_BITS + 4;   // holds 2 * 4.0
    localparam int MAG_W = flu_pkg::RATIO_W - 1;

    localparam logic [MAG_W-1:0] QUAD_M = MAG_W'(1) << (FRAC_BITS + 2);
    localparam logic [WK_W-1:0]  ONE_K  = WK_W'(1) << FRAC_BITS;
    localparam logic [WK_W-1:0]  TWO_K  = WK_W'(1) << (FRAC_BITS + 1);
    localparam logic [flu_pkg::DEN_W-1:0] ONE_D = flu_pkg::DEN_W'(1) << FRAC_BITS;

    // stage 1
    flu_pkg::t_ctl    r_s1_ctl;
    logic [MAG_W-1:0] r_s1_r;
    logic [CL_W-1:0]  r_s1_rc;
    flu_pkg::t_ctl    n_s1_ctl;
    logic [CL_W-1:0]  n_s1_rc;

    // stage 2
    flu_pkg::t_ctl                r_s2_ctl;
    logic [flu_pkg::DEN_W-1:0]    r_s2_rem;
    logic [flu_pkg::DEN_W-1:0]    r_s2_den;
    logic [PHI_W-1:0]             r_s2_aux;
    logic [PHI_W-1:0]             n_s2_aux;

    // beyond 4.0 every closed-form limiter is already saturated
    always_comb begin
        n_s1_ctl.valid = i_valid;
        n_s1_ctl.pos   = !i_ratio[MAG_W] && (i_ratio[MAG_W-1:0] != '0);
        n_s1_ctl.mode  = i_mode;
        n_s1_rc = (i_ratio[MAG_W-1:0] >= QUAD_M) ? CL_W'(QUAD_M)
                                                  : CL_W'(i_ratio[MAG_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_ctl <= n_s1_ctl;
            r_s1_r   <= i_ratio[MAG_W-1:0];
            r_s1_rc  <= n_s1_rc;
        end
    end

    always_comb begin
        logic [WK_W-1:0] rw;
        logic [WK_W-1:0] two_r;
        logic [WK_W-1:0] half;
        logic [WK_W-1:0] lo;
        logic [WK_W-1:0] hi;
        logic [WK_W-1:0] res;
        rw    = WK_W'(r_s1_rc);
        two_r = rw << 1;
        half  = (ONE_K + rw) >> 1;
        lo    = '0;
        hi    = '0;
        res   = '0;
        unique case (r_s1_ctl.mode)
            flu_pkg::MODE_MC: begin
                lo  = (two_r < half) ? two_r : half;
                res = (lo < TWO_K) ? lo : TWO_K;
            end
            flu_pkg::MODE_MINMOD: begin
                res = (rw < ONE_K) ? rw : ONE_K;
            end
            flu_pkg::MODE_SUPERBEE: begin
                lo  = (two_r < ONE_K) ? two_r : ONE_K;
                hi  = (rw < TWO_K) ? rw : TWO_K;
                res = (lo > hi) ? lo : hi;
            end
            flu_pkg::MODE_VANLEER: begin
                res = '0;   // comes from the divider
            end
            default: res = '0;
        endcase
        n_s2_aux = r_s1_ctl.pos ? PHI_W'(res) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_rem <= flu_pkg::DEN_W'(r_s1_r);
            r_s2_den <= ONE_D + flu_pkg::DEN_W'(r_s1_r);
            r_s2_aux <= n_s2_aux;
        end
    end

    assign o_ctl = r_s2_ctl;
    assign o_rem = r_s2_rem;
    assign o_den = r_s2_den;
    assign o_aux = r_s2_aux;

endmodule

/* rtl/flu_div_stage.sv */
// ----------------------------------------------------------------------------
// flu_div_stage - one stage of the restoring divider
// Retires NBITS quotient bits of 2r * 2^F / (1 + r); zeros shift in.
// ----------------------------------------------------------------------------
module flu_div_stage #(
    parameter int FRAC_BITS = flu_pkg::FRAC_BITS_DEF,
    parameter int NBITS     = flu_pkg::DIV_STEP
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  flu_pkg::t_ctl                i_ctl,
    input  logic [flu_pkg::DEN_W-1:0]    i_rem,
    input  logic [flu_pkg::DEN_W-1:0]    i_den,
    input  logic [FRAC_BITS:0]           i_quot,
    input  logic [FRAC_BITS+1:0]         i_aux,
    output flu_pkg::t_ctl                o_ctl,
    output logic [flu_pkg::DEN_W-1:0]    o_rem,
    output logic [flu_pkg::DEN_W-1:0]    o_den,
    output logic [FRAC_BITS:0]           o_quot,
    output logic [FRAC_BITS+1:0]         o_aux
);

    localparam int QW = FRAC_BITS + 1;
    localparam int DW = flu_pkg::DEN_W;

    flu_pkg::t_ctl          r_ctl;
    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_den;
    logic [QW-1:0]          r_quot;
    logic [FRAC_BITS+1:0]   r_aux;
    logic [DW-1:0]          n_rem;
    logic [QW-1:0]          n_quot;

    always_comb begin
        logic [DW:0] sh;
        logic        qb;
        n_rem  = i_rem;
        n_quot = i_quot;
        for (int k = 0; k < NBITS; k++) begin
            sh = {n_rem, 1'b0};
            qb = (sh >= {1'b0, i_den});
            if (qb) begin
                sh = sh - {1'b0, i_den};
            end
            n_rem  = sh[DW-1:0];
            n_quot = {n_quot[QW-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl  <= i_ctl;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
            r_aux  <= i_aux;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quot = r_quot;
    assign o_aux  = r_aux;

endmodule

/* rtl/flu_skid.sv */
// ----------------------------------------------------------------------------
// flu_skid - output register with skid slot
// Catches the word in flight when the sink stalls; ready is registered.
// ----------------------------------------------------------------------------
module flu_skid #(
    parameter int W = flu_pkg::FRAC_BITS_DEF + 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_skid_valid;
    logic [W-1:0] r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
                r_out_data  <= i_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= i_data;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

/* rtl/flux_limiter_unit.sv */
// ----------------------------------------------------------------------------
// flux_limiter_unit - TVD flux limiter (MC, minmod, superbee, Van Leer)
//
// Input stream: one signed Q16.16 slope ratio r per word on s_axis tdata.
// Output stream: one unsigned Q.16 limiter value phi (0 .. 2.0) per word,
// zero-padded to whole bytes, in the same order as the ratios arrived.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write the 2-bit limiter code
// (0 MC, 1 minmod, 2 superbee, 3 Van Leer); change it only while idle.
// Throughput: one word per cycle, sustained while the sink keeps tready high.
// Depth: 3 + ceil((FRAC_BITS + 1) / 2) register stages, 12 at FRAC_BITS = 16,
// set by the restoring divider for Van Leer, which retires two quotient bits
// per stage, the last stage retiring whatever is left. The closed-form
// limiters ride alongside the divider so every mode has the same latency.
// Reset: synchronous, active low; empties the pipe and selects MC.
// Stall: while the sink holds tready low the pipe keeps running until the
// skid slot is taken; s_axis tready then drops in the following cycle, registered,
// and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module flux_limiter_unit #(
    parameter int FRAC_BITS = flu_pkg::FRAC_BITS_DEF,
    localparam int OUT_W    = ((FRAC_BITS + 2 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic [flu_pkg::CFG_W-1:0]    i_cfg_wr_data,   // limiter_mode
    // ratio stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [flu_pkg::RATIO_W-1:0]  i_s_axis_tdata,  // [31:0] ratio
    // phi stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [OUT_W-1:0]             o_m_axis_tdata   // [F+1:0] phi, rest 0
);

    localparam int PHI_W = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int STEP  = flu_pkg::DIV_STEP;
    localparam int NST   = (QW + STEP - 1) / STEP;
    localparam int DW    = flu_pkg::DEN_W;

    flu_pkg::t_mode r_mode;
    logic           w_en;     // whole pipe advances together

    flu_pkg::t_ctl    w_ctl  [0:NST];
    logic [DW-1:0]    w_rem  [0:NST];
    logic [DW-1:0]    w_den  [0:NST];
    logic [QW-1:0]    w_quot [0:NST];
    logic [PHI_W-1:0] w_aux  [0:NST];

    logic [PHI_W-1:0] w_phi;
    logic [PHI_W-1:0] w_out_phi;

    // limiter code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= flu_pkg::MODE_MC;
        end else if (i_cfg_wr_en) begin
            r_mode <= flu_pkg::t_mode'(i_cfg_wr_data);
        end
    end

    assign o_s_axis_tready = w_en;

    // stages 1-2: capture, clamp, closed-form limiters, divider seed
    flu_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_ratio (i_s_axis_tdata),
        .i_mode  (r_mode),
        .o_ctl   (w_ctl[0]),
        .o_rem   (w_rem[0]),
        .o_den   (w_den[0]),
        .o_aux   (w_aux[0])
    );

    // quotient builds up from nothing; each stage shifts its new bits in below it
    assign w_quot[0] = '0;

    // Van Leer: 2r * 2^F / (1 + r), MSB first, STEP bits per stage, the last stage the rest
    for (genvar g = 0; g < NST; g++) begin : g_div
        localparam int NB = (g == NST - 1) ? (QW - STEP * (NST - 1)) : STEP;
        flu_div_stage #(
            .FRAC_BITS (FRAC_BITS),
            .NBITS     (NB)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quot  (w_quot[g]),
            .i_aux   (w_aux[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quot  (w_quot[g+1]),
            .o_aux   (w_aux[g+1])
        );
    end

    // final pick: non-positive ratio gives 0 in every mode
    always_comb begin
        if (!w_ctl[NST].pos) begin
            w_phi = '0;
        end else if (w_ctl[NST].mode == flu_pkg::MODE_VANLEER) begin
            w_phi = PHI_W'(w_quot[NST]);
        end else begin
            w_phi = w_aux[NST];
        end
    end

    flu_skid #(
        .W (PHI_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ctl[NST].valid),
        .i_data  (w_phi),
        .o_ready (w_en),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out_phi),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = OUT_W'(w_out_phi);

endmodule

/* rtl/flu_chk.sv */
// ----------------------------------------------------------------------------
// flu_chk - port-level checks for flux_limiter_unit
// Watches reset, the stall path and the phi range; bound to the top level.
// ----------------------------------------------------------------------------
`include "flux_limiter_unit_assert.svh"

module flu_chk #(
    parameter int FRAC_BITS = flu_pkg::FRAC_BITS_DEF,
    localparam int OUT_W    = ((FRAC_BITS + 2 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam logic [OUT_W-1:0] PHI_MAX = OUT_W'(2) << FRAC_BITS;

    logic w_in_any;
    assign w_in_any = i_s_axis_tvalid;

    // reset empties the output
    `FLU_ASSERT_RST(a_rst_empty, !i_rst_n, !o_m_axis_tvalid, "output valid after reset")

    // a held word holds its data
    `FLU_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled phi changed")

    // input back-pressure only while a word waits at the output
    `FLU_ASSERT_NOW(a_bp_cause, !o_s_axis_tready, o_m_axis_tvalid, "ready low with empty output")

    // ready only drops after the sink refused a word
    `FLU_ASSERT_NOW(a_bp_fall, $fell(o_s_axis_tready), $past(o_m_axis_tvalid && !i_m_axis_tready), "ready dropped without sink stall")

    // phi never above 2.0, padding zero
    `FLU_ASSERT_NOW(a_range, o_m_axis_tvalid && (w_in_any || !w_in_any), o_m_axis_tdata <= PHI_MAX, "phi out of range")

endmodule

bind flux_limiter_unit flu_chk #(
    .FRAC_BITS (FRAC_BITS)
) u_flu_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* test/flux_limiter_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_limiter_unit_test - self-checking bench for the TVD flux limiter
// Streams slope ratios through all four limiters, predicts each phi word in
// the bench and compares it in order with what leaves the master side. Both
// sides idle in random bursts; one long sink hold-off fills the pipe.
// ----------------------------------------------------------------------------
module flux_limiter_unit_test;

    localparam int FRAC       = flu_pkg::FRAC_BITS_DEF;
    localparam int PHI_W      = FRAC + 2;
    localparam int OUT_W      = ((FRAC + 2 + 7) / 8) * 8;
    localparam int LATENCY    = 3 + (FRAC + 2) / 2;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 75;
    localparam int LONG_HOLD  = 80;
    localparam int CYCLE_CAP  = 200000;

    // ------------------------------------------------------------------------
    // phi predictor and in-order store of expected words
    // ------------------------------------------------------------------------
    class phi_scoreboard;
        logic [PHI_W-1:0] expected_phi[$];
        flu_pkg::t_mode   mode = flu_pkg::MODE_MC;
        int               errors = 0;

        function logic [PHI_W-1:0] limit_phi(logic [flu_pkg::RATIO_W-1:0] ratio);
            longint r;
            longint one;
            longint two;
            longint phi;
            r   = longint'($signed(ratio));
            one = longint'(1) << FRAC;
            two = 2 * one;
            if (r <= 0) begin
                phi = 0;
            end else begin
                case (mode)
                    flu_pkg::MODE_MC: begin
                        phi = (one + r) / 2;
                        if (2 * r < phi) phi = 2 * r;
                        if (two < phi) phi = two;
                    end
                    flu_pkg::MODE_MINMOD: begin
                        phi = (r < one) ? r : one;
                    end
                    flu_pkg::MODE_SUPERBEE: begin
                        phi = (2 * r < one) ? 2 * r : one;
                        if (((r < two) ? r : two) > phi) phi = (r < two) ? r : two;
                    end
                    default: begin
                        // 2r / (1 + r), truncated
                        phi = ((r * 2) << FRAC) / (one + r);
                    end
                endcase
            end
            return phi[PHI_W-1:0];
        endfunction

        function void note_ratio(logic [flu_pkg::RATIO_W-1:0] ratio);
            expected_phi.push_back(limit_phi(ratio));
        endfunction

        function void check_phi(logic [OUT_W-1:0] word);
            logic [PHI_W-1:0] want;
            if (expected_phi.size() == 0) begin
                $error("phi: expected none, actual %0d", word[PHI_W-1:0]);
                errors++;
                return;
            end
            want = expected_phi.pop_front();
            if (word[PHI_W-1:0] !== want) begin
                $error("phi: expected %0d, actual %0d", want, word[PHI_W-1:0]);
                errors++;
            end
            if (word[OUT_W-1:PHI_W] !== '0) begin
                $error("pad: expected 0, actual %0h", word[OUT_W-1:PHI_W]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_wr_en     = 1'b0;
    logic [flu_pkg::CFG_W-1:0]     i_cfg_wr_data   = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [flu_pkg::RATIO_W-1:0]   i_s_axis_tdata  = '0;   // [31:0] ratio
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b1;
    logic [OUT_W-1:0]              o_m_axis_tdata;         // [17:0] phi, rest 0

    phi_scoreboard sb = new();

    bit idle_on    = 1'b1;   // random bursts on both sides
    int hold_asked = 0;      // long sink hold-offs requested by the sender

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    flux_limiter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : sink_side
        int stall_left;
        int hold_done;
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_done < hold_asked) begin
            hold_done++;
            stall_left = LONG_HOLD - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // phi words are checked as they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_phi(o_m_axis_tdata);
        end
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        int cycles;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("flux_limiter_unit_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks; each is entered and left just after a rising edge
    // ------------------------------------------------------------------------
    task automatic write_mode(input flu_pkg::t_mode m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.mode = m;
    endtask

    // offer one ratio, hold it until taken, then maybe go quiet for a burst
    task automatic send_ratio(input logic [flu_pkg::RATIO_W-1:0] ratio);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ratio;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_ratio(ratio);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every phi word still owed
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_phi.size() != 0) @(posedge i_clk);
    endtask

    // ratios weighted toward the interesting part, 0 .. 4.0, and the breakpoints
    function automatic logic [flu_pkg::RATIO_W-1:0] pick_ratio();
        logic [flu_pkg::RATIO_W-1:0] knee[5];
        knee = '{32'h0000_5555, 32'h0000_8000, 32'h0001_0000,
                 32'h0002_0000, 32'h0003_0000};
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return -$urandom_range(1, 32'h7FFF_FFFF);
            2:       return knee[$urandom_range(0, 4)] + $urandom_range(0, 6) - 3;
            3:       return $urandom_range(0, 16);
            4:       return $urandom_range(32'h0004_0000, 32'h7FFF_FFFF);
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [flu_pkg::RATIO_W-1:0] corner[6];
        flu_pkg::t_mode m;
        corner = '{32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
                   32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: the corner ratios under each limiter
        for (int k = 0; k < 4; k++) begin
            write_mode(flu_pkg::t_mode'(k));
            foreach (corner[j]) send_ratio(corner[j]);
            drain();
        end

        // random phases; the first four visit each limiter, the rest pick one
        for (int p = 0; p < PHASES; p++) begin
            m = (p < 4) ? flu_pkg::t_mode'(p) : flu_pkg::t_mode'($urandom_range(0, 3));
            idle_on = (p != PHASES - 1);
            write_mode(m);
            if (p == 2) hold_asked++;   // sink sits still while the pipe backs up
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_ratio(pick_ratio());
            end
            drain();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("flux_limiter_unit_test OK");
        end else begin
            $display("flux_limiter_unit_test NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/flu_pkg.sv
rtl/flu_front.sv
rtl/flu_div_stage.sv
rtl/flu_skid.sv
rtl/flux_limiter_unit.sv
rtl/flu_chk.sv
test/flux_limiter_unit_test.sv
